// File: sv/bpc_pkg.sv
// Shared types and constants for the barometric compensation unit.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package bpc_pkg;

    localparam int RAW_W    = 24;
    localparam int CAL_W    = 16;
    localparam int TEMP_W   = 19;
    localparam int PRESS_W  = 22;
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;
    localparam int NSTAGE   = 6;
    localparam int ACC_W    = 40;

    localparam logic [19:0]        TEMP_REF  = 20'd2000;
    localparam logic [PRESS_W-1:0] PRESS_MAX = 22'h3F_FFFF;

    typedef enum logic [2:0] {
        REG_SENS      = 3'd0,
        REG_OFF       = 3'd1,
        REG_SENS_TC   = 3'd2,
        REG_OFF_TC    = 3'd3,
        REG_TEMP_REF  = 3'd4,
        REG_TEMP_SENS = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [CAL_W-1:0] sens;
        logic [CAL_W-1:0] off;
        logic [CAL_W-1:0] sens_tc;
        logic [CAL_W-1:0] off_tc;
        logic [CAL_W-1:0] temp_ref;
        logic [CAL_W-1:0] temp_sens;
    } t_cal;

    // Load enables, one per pipeline stage; bit 0 is the input stage.
    typedef struct packed {
        logic [NSTAGE-1:0] en;
    } t_pipe_ctl;

endpackage

`default_nettype wire

// File: sv/bpc_samp_if.sv
// Input channel: one raw pressure and one raw temperature conversion per transaction.
// Depends on bpc_pkg for the field widths.
`default_nettype none

interface bpc_samp_if import bpc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] raw_pressure;
    logic [RAW_W-1:0] raw_temperature;

    modport source (output valid, output raw_pressure, output raw_temperature, input ready);
    modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

`default_nettype wire

// File: sv/bpc_res_if.sv
// Result channel: compensated temperature and pressure per transaction.
// Depends on bpc_pkg for the field widths.
`default_nettype none

interface bpc_res_if import bpc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [TEMP_W-1:0]  temperature_cx100;
    logic [PRESS_W-1:0]        pressure_x16;

    modport source (output valid, output temperature_cx100, output pressure_x16, input ready);
    modport sink   (input valid, input temperature_cx100, input pressure_x16, output ready);
endinterface

`default_nettype wire

// File: sv/bpc_apb_regs.sv
// APB register file holding the six calibration words.
// Depends on bpc_pkg for the register indexes and the t_cal struct.
`default_nettype none

module bpc_apb_regs import bpc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output t_cal                   o_cal
);

    t_cal     r_cal;
    t_cal     n_cal;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx = t_reg_idx'(paddr[APB_AW-1:2]);
    assign w_wr  = psel && penable && pwrite;

    always_comb begin
        n_cal = r_cal;
        if (w_wr) begin
            unique case (w_idx)
                REG_SENS:      n_cal.sens      = pwdata[CAL_W-1:0];
                REG_OFF:       n_cal.off       = pwdata[CAL_W-1:0];
                REG_SENS_TC:   n_cal.sens_tc   = pwdata[CAL_W-1:0];
                REG_OFF_TC:    n_cal.off_tc    = pwdata[CAL_W-1:0];
                REG_TEMP_REF:  n_cal.temp_ref  = pwdata[CAL_W-1:0];
                REG_TEMP_SENS: n_cal.temp_sens = pwdata[CAL_W-1:0];
                default:       n_cal = r_cal;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_SENS:      prdata = APB_DW'(r_cal.sens);
            REG_OFF:       prdata = APB_DW'(r_cal.off);
            REG_SENS_TC:   prdata = APB_DW'(r_cal.sens_tc);
            REG_OFF_TC:    prdata = APB_DW'(r_cal.off_tc);
            REG_TEMP_REF:  prdata = APB_DW'(r_cal.temp_ref);
            REG_TEMP_SENS: prdata = APB_DW'(r_cal.temp_sens);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else begin
            r_cal <= n_cal;
        end
    end

    assign o_cal = r_cal;

endmodule

`default_nettype wire

// File: sv/bpc_pipe_ctrl.sv
// Valid bits and per-stage load enables of the six-stage datapath.
// Depends on bpc_pkg for NSTAGE and t_pipe_ctl.
`default_nettype none

module bpc_pipe_ctrl import bpc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_out_ready,
    output logic      o_in_ready,
    output logic      o_out_valid,
    output t_pipe_ctl o_ctl
);

    logic [NSTAGE-1:0] r_v;
    logic [NSTAGE-1:0] n_v;
    logic [NSTAGE-1:0] w_en;

    // A stage may load when it is empty or when the stage after it loads,
    // so bubbles are squeezed out while the receiver stalls.
    always_comb begin
        w_en[NSTAGE-1] = !r_v[NSTAGE-1] || i_out_ready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    always_comb begin
        n_v = r_v;
        if (w_en[0]) n_v[0] = i_in_valid;
        for (int k = 1; k < NSTAGE; k++) begin
            if (w_en[k]) n_v[k] = r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_v[NSTAGE-1];
    assign o_ctl.en    = w_en;

    a_ready_when_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v != '1) |-> o_in_ready)
        else $error("input stalled although a stage is empty");

    a_fill_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !(o_out_valid && i_out_ready))
        |=> ($countones(r_v) == $past($countones(r_v)) + 1))
        else $error("accepted transaction lost in the pipeline");

    a_drain_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!(i_in_valid && o_in_ready) && o_out_valid && i_out_ready)
        |=> ($countones(r_v) + 1 == $past($countones(r_v))))
        else $error("delivered transaction repeated in the pipeline");

endmodule

`default_nettype wire

// File: sv/bpc_front.sv
// Stages one to four: temperature difference, first- and second-order terms.
// Depends on bpc_pkg; load enables come from bpc_pipe_ctrl.
`default_nettype none

module bpc_front import bpc_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_pipe_ctl               i_ctl,
    input  wire t_cal                    i_cal,
    input  wire logic [RAW_W-1:0]        i_raw_pressure,
    input  wire logic [RAW_W-1:0]        i_raw_temperature,
    output logic      [RAW_W-1:0]        o_d1,
    output logic signed [TEMP_W-1:0]     o_temp,
    output logic signed [ACC_W-1:0]      o_off,
    output logic signed [ACC_W-1:0]      o_sens
);

    // Stage 1
    logic [RAW_W-1:0]    r_d1_1;
    logic signed [24:0]  r_dt_1;
    logic signed [24:0]  n_dt_1;
    // Stage 2
    logic [RAW_W-1:0]    r_d1_2;
    logic signed [41:0]  r_pt_2, r_poff_2, r_psens_2;
    logic signed [49:0]  r_sq_2;
    logic signed [41:0]  n_pt_2, n_poff_2, n_psens_2;
    logic signed [49:0]  n_sq_2;
    // Stage 3
    logic [RAW_W-1:0]    r_d1_3;
    logic signed [19:0]  r_temp_3, n_temp_3;
    logic [34:0]         r_dsq_3, n_dsq_3;
    logic signed [ACC_W-1:0] r_off_3, r_sens_3, n_off_3, n_sens_3;
    logic signed [18:0]  w_dev;
    logic                w_low;
    logic [17:0]         w_corr_t;
    logic signed [37:0]  w_dev_sq;
    logic signed [19:0]  w_temp1;
    // Stage 4
    logic [RAW_W-1:0]    r_d1_4;
    logic signed [TEMP_W-1:0] r_temp_4;
    logic signed [ACC_W-1:0]  r_off_4, r_sens_4, n_off_4, n_sens_4;
    logic [36:0]         w_five_sq;

    assign n_dt_1 = signed'({1'b0, i_raw_temperature})
                  - signed'({1'b0, i_cal.temp_ref, 8'd0});

    assign n_pt_2    = 42'(r_dt_1) * 42'(signed'({1'b0, i_cal.temp_sens}));
    assign n_poff_2  = 42'(r_dt_1) * 42'(signed'({1'b0, i_cal.off_tc}));
    assign n_psens_2 = 42'(r_dt_1) * 42'(signed'({1'b0, i_cal.sens_tc}));
    assign n_sq_2    = 50'(r_dt_1) * 50'(r_dt_1);

    // The first-order temperature is below the reference exactly when the
    // slope product is negative, so the deviation is the shifted product.
    assign w_dev    = signed'(r_pt_2[41:23]);
    assign w_low    = r_pt_2[41];
    assign w_corr_t = r_sq_2[48:31];
    assign w_dev_sq = 38'(w_dev) * 38'(w_dev);
    assign w_temp1  = signed'(TEMP_REF) + 20'(w_dev);
    assign n_temp_3 = w_low ? (w_temp1 - signed'({2'b00, w_corr_t})) : w_temp1;
    assign n_dsq_3  = w_low ? w_dev_sq[34:0] : '0;
    assign n_off_3  = ACC_W'(signed'({1'b0, i_cal.off, 16'd0}))
                    + ACC_W'(signed'(r_poff_2[41:7]));
    assign n_sens_3 = ACC_W'(signed'({1'b0, i_cal.sens, 15'd0}))
                    + ACC_W'(signed'(r_psens_2[41:8]));

    // Offset correction is 5/2 of the squared deviation, sensitivity half of that.
    assign w_five_sq = {r_dsq_3, 2'b00} + 37'(r_dsq_3);
    assign n_off_4   = r_off_3  - ACC_W'(signed'({1'b0, w_five_sq[36:1]}));
    assign n_sens_4  = r_sens_3 - ACC_W'(signed'({1'b0, w_five_sq[36:2]}));

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r_d1_1 <= i_raw_pressure;
            r_dt_1 <= n_dt_1;
        end
        if (i_ctl.en[1]) begin
            r_d1_2    <= r_d1_1;
            r_pt_2    <= n_pt_2;
            r_poff_2  <= n_poff_2;
            r_psens_2 <= n_psens_2;
            r_sq_2    <= n_sq_2;
        end
        if (i_ctl.en[2]) begin
            r_d1_3   <= r_d1_2;
            r_temp_3 <= n_temp_3;
            r_dsq_3  <= n_dsq_3;
            r_off_3  <= n_off_3;
            r_sens_3 <= n_sens_3;
        end
        if (i_ctl.en[3]) begin
            r_d1_4   <= r_d1_3;
            r_temp_4 <= r_temp_3[TEMP_W-1:0];
            r_off_4  <= n_off_4;
            r_sens_4 <= n_sens_4;
        end
    end

    assign o_d1   = r_d1_4;
    assign o_temp = r_temp_4;
    assign o_off  = r_off_4;
    assign o_sens = r_sens_4;

    a_low_has_square: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.en[2] && w_low) |=> (r_dsq_3 != '0))
        else $error("second-order term missing below the reference temperature");

endmodule

`default_nettype wire

// File: sv/bpc_back.sv
// Stages five and six: split pressure product, final sum, floor and saturation.
// Depends on bpc_pkg; load enables come from bpc_pipe_ctrl.
`default_nettype none

module bpc_back import bpc_pkg::*; (
    input  wire logic                    i_clk,
    input  wire t_pipe_ctl               i_ctl,
    input  wire logic [RAW_W-1:0]        i_d1,
    input  wire logic signed [TEMP_W-1:0] i_temp,
    input  wire logic signed [ACC_W-1:0] i_off,
    input  wire logic signed [ACC_W-1:0] i_sens,
    output logic signed [TEMP_W-1:0]     o_temp,
    output logic [PRESS_W-1:0]           o_press
);

    localparam int HALF = ACC_W / 2;

    logic signed [TEMP_W-1:0] r_temp_5;
    logic signed [ACC_W-1:0]  r_off_5;
    logic [RAW_W+HALF-1:0]    r_pp_lo_5, n_pp_lo_5;
    logic signed [RAW_W+HALF:0] r_pp_hi_5, n_pp_hi_5;
    logic signed [65:0]       w_numer;
    logic signed [33:0]       w_press;
    logic [PRESS_W-1:0]       n_press;
    logic signed [TEMP_W-1:0] r_temp_6;
    logic [PRESS_W-1:0]       r_press_6;

    // D1 * SENS is formed from a low unsigned half and a high signed half.
    assign n_pp_lo_5 = (RAW_W+HALF)'(i_d1) * (RAW_W+HALF)'(i_sens[HALF-1:0]);
    assign n_pp_hi_5 = (RAW_W+HALF+1)'(signed'({1'b0, i_d1}))
                     * (RAW_W+HALF+1)'(signed'(i_sens[ACC_W-1:HALF]));

    assign w_numer = (66'(r_pp_hi_5) <<< HALF)
                   + 66'(signed'({1'b0, r_pp_lo_5}))
                   - (66'(r_off_5) <<< 21);
    assign w_press = w_numer[65:32];

    always_comb begin
        if (w_press[33]) begin
            n_press = '0;
        end else if (|w_press[32:PRESS_W]) begin
            n_press = PRESS_MAX;
        end else begin
            n_press = w_press[PRESS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[4]) begin
            r_temp_5  <= i_temp;
            r_off_5   <= i_off;
            r_pp_lo_5 <= n_pp_lo_5;
            r_pp_hi_5 <= n_pp_hi_5;
        end
        if (i_ctl.en[5]) begin
            r_temp_6  <= r_temp_5;
            r_press_6 <= n_press;
        end
    end

    assign o_temp  = r_temp_6;
    assign o_press = r_press_6;

endmodule

`default_nettype wire

// File: sv/baro_pressure_temp_compensation_unit.sv
// Barometric pressure and temperature compensation with a second-order
// low-temperature correction.
//
// Usage: the six calibration words are written over the APB port at byte
// addresses 0, 4, ... 20 while the block is idle; reads return them. Each
// transaction on i_samp carries one raw pressure and one raw temperature
// conversion; each transaction on o_res returns the temperature in 0.01 C
// and the pressure in 1/16 Pa, floored and saturated.
// The item is captured by the first of six register stages at the accepting
// edge and moves on one stage whenever the next stage loads (difference,
// three parallel products and the square, first-order sums with the deviation
// square, second-order subtraction, split pressure product, final sum with
// saturation).
// Throughput is one transaction per cycle while o_res.ready is held high.
// Reset clears all valid bits and all calibration words to zero.
// When the receiver stalls, the result holds in the last stage and the
// earlier stages keep filling until every stage is occupied; only then is
// i_samp.ready dropped. Nothing is lost or repeated.
// Depends on bpc_pkg, the two channel interfaces and the bpc_* submodules.
`default_nettype none

module baro_pressure_temp_compensation_unit import bpc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    bpc_samp_if.sink               i_samp,
    bpc_res_if.source              o_res,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    t_cal                     w_cal;
    t_pipe_ctl                w_ctl;
    logic                     w_in_ready;
    logic                     w_out_valid;
    logic [RAW_W-1:0]         w_d1;
    logic signed [TEMP_W-1:0] w_temp;
    logic signed [ACC_W-1:0]  w_off;
    logic signed [ACC_W-1:0]  w_sens;
    logic signed [TEMP_W-1:0] w_temp_o;
    logic [PRESS_W-1:0]       w_press_o;

    assign pready = 1'b1;

    bpc_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cal   (w_cal)
    );

    bpc_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_samp.valid),
        .i_out_ready (o_res.ready),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .o_ctl       (w_ctl)
    );

    bpc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (w_ctl),
        .i_cal             (w_cal),
        .i_raw_pressure    (i_samp.raw_pressure),
        .i_raw_temperature (i_samp.raw_temperature),
        .o_d1              (w_d1),
        .o_temp            (w_temp),
        .o_off             (w_off),
        .o_sens            (w_sens)
    );

    bpc_back u_back (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_d1    (w_d1),
        .i_temp  (w_temp),
        .i_off   (w_off),
        .i_sens  (w_sens),
        .o_temp  (w_temp_o),
        .o_press (w_press_o)
    );

    assign i_samp.ready            = w_in_ready;
    assign o_res.valid             = w_out_valid;
    assign o_res.temperature_cx100 = w_temp_o;
    assign o_res.pressure_x16      = w_press_o;

endmodule

`default_nettype wire

// File: test/bpc_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the barometric compensation unit: it follows the calibration
// writes on the APB port, predicts each result and compares it with o_res.
// Depends on bpc_pkg and the two channel interfaces.

module bpc_result_checker import bpc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    bpc_samp_if                    i_samp,
    bpc_res_if                     i_res,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic              pready,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output int                     o_errors,
    output int                     o_pending
);

    localparam longint TEMP_REF_CX100 = 2000;

    typedef struct packed {
        logic [TEMP_W-1:0]  temperature_cx100;
        logic [PRESS_W-1:0] pressure_x16;
    } t_comp_result;

    t_cal         cal_words;
    t_comp_result expected_q[$];
    int           error_count = 0;
    int           pending_count = 0;

    assign o_errors  = error_count;
    assign o_pending = pending_count;

    // All arithmetic is exact in 64 bits; >>> on a signed operand floors.
    function automatic t_comp_result compensate(input t_cal cw, input logic [RAW_W-1:0] raw_p,
                                                input logic [RAW_W-1:0] raw_t);
        longint d1, d2, c1, c2, c3, c4, c5, c6;
        longint delta_t, temp, off, sens, dev, numer, press;
        longint corr_t, corr_off, corr_sens;
        t_comp_result r;
        d1 = raw_p;
        d2 = raw_t;
        c1 = cw.sens;
        c2 = cw.off;
        c3 = cw.sens_tc;
        c4 = cw.off_tc;
        c5 = cw.temp_ref;
        c6 = cw.temp_sens;
        corr_t = 0;
        corr_off = 0;
        corr_sens = 0;

        delta_t = d2 - c5 * 256;
        temp    = TEMP_REF_CX100 + ((delta_t * c6) >>> 23);
        off     = c2 * 65536 + ((c4 * delta_t) >>> 7);
        sens    = c1 * 32768 + ((c3 * delta_t) >>> 8);

        // Cold branch and its off/sens terms use the first-order temperature.
        if (temp < TEMP_REF_CX100) begin
            dev       = temp - TEMP_REF_CX100;
            corr_t    = (delta_t * delta_t) >>> 31;
            corr_off  = (5 * dev * dev) / 2;
            corr_sens = corr_off / 2;
        end
        temp = temp - corr_t;
        off  = off - corr_off;
        sens = sens - corr_sens;

        numer = d1 * sens - off * 2097152;
        press = numer >>> 32;
        if (press < 0)
            press = 0;
        if (press > longint'(PRESS_MAX))
            press = longint'(PRESS_MAX);

        r.temperature_cx100 = temp[TEMP_W-1:0];
        r.pressure_x16      = press[PRESS_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_comp_result want;
        if (!i_rst_n) begin
            cal_words = '0;
            expected_q.delete();
        end else begin
            if (i_samp.valid && i_samp.ready)
                expected_q.push_back(compensate(cal_words, i_samp.raw_pressure,
                                                i_samp.raw_temperature));
            if (i_res.valid && i_res.ready) begin
                if (expected_q.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result, expected none, got temperature %0d pressure %0d",
                             $time, $signed(i_res.temperature_cx100), i_res.pressure_x16);
                end else begin
                    want = expected_q.pop_front();
                    if (i_res.temperature_cx100 !== want.temperature_cx100) begin
                        error_count++;
                        $display("%0t: temperature_cx100 expected %0d, got %0d", $time,
                                 $signed(want.temperature_cx100),
                                 $signed(i_res.temperature_cx100));
                    end
                    if (i_res.pressure_x16 !== want.pressure_x16) begin
                        error_count++;
                        $display("%0t: pressure_x16 expected %0d, got %0d", $time,
                                 want.pressure_x16, i_res.pressure_x16);
                    end
                end
            end
            // Writes to the two spare indexes fall through and change nothing.
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[APB_AW-1:2]))
                    REG_SENS:      cal_words.sens      = pwdata[CAL_W-1:0];
                    REG_OFF:       cal_words.off       = pwdata[CAL_W-1:0];
                    REG_SENS_TC:   cal_words.sens_tc   = pwdata[CAL_W-1:0];
                    REG_OFF_TC:    cal_words.off_tc    = pwdata[CAL_W-1:0];
                    REG_TEMP_REF:  cal_words.temp_ref  = pwdata[CAL_W-1:0];
                    REG_TEMP_SENS: cal_words.temp_sens = pwdata[CAL_W-1:0];
                    default: ;
                endcase
            end
        end
        pending_count = expected_q.size();
    end

endmodule

// File: test/baro_pressure_temp_compensation_unit_tb.sv
`timescale 1ns / 100ps
// Testbench top for the barometric compensation unit: clock, reset, calibration
// writes, sample stimulus with random idling, and the verdict.
// Depends on bpc_pkg, the channel interfaces, the block and bpc_result_checker.

module baro_pressure_temp_compensation_unit_tb;
    import bpc_pkg::*;

    localparam int NUM_CAL_REGS    = 6;
    localparam int SPARE_REG_A     = 6;
    localparam int SPARE_REG_B     = 7;
    localparam int RAW_TOP         = (1 << RAW_W) - 1;
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 116;
    localparam int BURST_ITEMS     = 40;
    localparam int HOLD_CYCLES     = 300;
    localparam int QUIET_LIMIT     = 4000;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;
    typedef enum int {CAL_TYPICAL, CAL_RANDOM, CAL_CORNERS} t_cal_style;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int          error_count;
    int          pending_count;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          hold_requests = 0;
    int          hold_served = 0;
    int          quiet_cycles = 0;
    logic [15:0] cal_img [NUM_CAL_REGS];

    bpc_samp_if samp_ch ();
    bpc_res_if  res_ch ();

    baro_pressure_temp_compensation_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_samp  (samp_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    bpc_result_checker i_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_samp    (samp_ch),
        .i_res     (res_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .pready    (pready),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .o_errors  (error_count),
        .o_pending (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_served != hold_requests) begin
                hold_served++;
                repeat (HOLD_CYCLES) begin
                    res_ch.ready <= 1'b0;
                    @(negedge i_clk);
                end
            end
            res_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((samp_ch.valid && samp_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("baro_pressure_temp_compensation_unit_tb: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [15:0] typical_cal(input int idx);
        case (t_reg_idx'(idx))
            REG_SENS:      return 16'd40127;
            REG_OFF:       return 16'd36924;
            REG_SENS_TC:   return 16'd23317;
            REG_OFF_TC:    return 16'd23282;
            REG_TEMP_REF:  return 16'd33464;
            REG_TEMP_SENS: return 16'd28312;
            default:       return 16'd0;
        endcase
    endfunction

    function automatic logic [RAW_W-1:0] pick_pressure();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return RAW_W'($urandom);
            default: return RAW_W'($urandom_range(10000000, 8000000));
        endcase
    endfunction

    // Most temperatures land near the reference code so both sides of 20 C are hit.
    function automatic logic [RAW_W-1:0] pick_temperature();
        int v;
        v = int'(cal_img[REG_TEMP_REF]) * 256 + int'($urandom_range(3000000)) - 1500000;
        if (v < 0)
            v = 0;
        if (v > RAW_TOP)
            v = RAW_TOP;
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3:    return RAW_W'($urandom);
            default: return RAW_W'(v);
        endcase
    endfunction

    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_NONE:     begin idle_pct = 0;  stall_pct = 0;  end
            IDLE_SENDER:   begin idle_pct = 62; stall_pct = 0;  end
            IDLE_RECEIVER: begin idle_pct = 0;  stall_pct = 62; end
            IDLE_BOTH:     begin idle_pct = 14; stall_pct = 14; end
            default:       begin idle_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    task automatic send_sample(input logic [RAW_W-1:0] p, input logic [RAW_W-1:0] t);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            samp_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        samp_ch.valid           <= 1'b1;
        samp_ch.raw_pressure    <= p;
        samp_ch.raw_temperature <= t;
        do @(posedge i_clk); while (!samp_ch.ready);
    endtask

    task automatic drain();
        @(negedge i_clk);
        samp_ch.valid <= 1'b0;
        wait (pending_count == 0);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic cal_write(input int idx, input logic [15:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= APB_AW'(idx * 4);
        pwdata  <= APB_DW'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_cal(input bit with_spare);
        drain();
        for (int r = 0; r < NUM_CAL_REGS; r++)
            cal_write(r, cal_img[r]);
        if (with_spare) begin
            cal_write(SPARE_REG_A, 16'($urandom));
            cal_write(SPARE_REG_B, 16'hFFFF);
        end
    endtask

    task automatic choose_cal(input t_cal_style style);
        for (int r = 0; r < NUM_CAL_REGS; r++) begin
            case (style)
                CAL_TYPICAL: cal_img[r] = 16'(int'(typical_cal(r)) +
                                              int'($urandom_range(4000)) - 2000);
                CAL_RANDOM:  cal_img[r] = 16'($urandom);
                default: begin
                    case ($urandom_range(2))
                        0:       cal_img[r] = 16'h0000;
                        1:       cal_img[r] = 16'hFFFF;
                        default: cal_img[r] = 16'($urandom);
                    endcase
                end
            endcase
        end
    endtask

    initial begin
        i_rst_n                 = 1'b0;
        samp_ch.valid           = 1'b0;
        samp_ch.raw_pressure    = '0;
        samp_ch.raw_temperature = '0;
        psel                    = 1'b0;
        penable                 = 1'b0;
        pwrite                  = 1'b0;
        paddr                   = '0;
        pwdata                  = '0;
        for (int r = 0; r < NUM_CAL_REGS; r++)
            cal_img[r] = 16'h0000;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Zero calibration straight out of reset.
        set_idling(IDLE_NONE);
        send_sample('0, '0);
        send_sample('1, '1);
        send_sample(24'h800000, 24'h400000);

        // Typical calibration: warm, cold, very cold, and the edge of the cold branch.
        for (int r = 0; r < NUM_CAL_REGS; r++)
            cal_img[r] = typical_cal(r);
        apply_cal(1'b1);
        set_idling(IDLE_BOTH);
        send_sample(24'd9085466, 24'd8569150);
        send_sample(24'd9085466, 24'd8000000);
        send_sample(24'd9085466, 24'd0);
        send_sample(24'd0, 24'd8569150);
        send_sample('1, 24'd8569150);
        send_sample('1, '1);
        send_sample(24'd1, 24'd8566784);
        send_sample(24'd9085466, 24'd8566783);

        // All calibration words at their maximum.
        for (int r = 0; r < NUM_CAL_REGS; r++)
            cal_img[r] = 16'hFFFF;
        apply_cal(1'b0);
        send_sample('1, '0);
        send_sample('1, '1);
        send_sample('0, '1);
        send_sample('1, 24'hFFFF00);

        // Large sensitivity alone drives the pressure near and past its upper limit.
        for (int r = 0; r < NUM_CAL_REGS; r++)
            cal_img[r] = 16'h0000;
        cal_img[REG_SENS] = 16'hFFFF;
        apply_cal(1'b0);
        send_sample('1, '0);
        send_sample(24'h800000, 24'h123456);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph % 2 == 0)
                choose_cal(CAL_TYPICAL);
            else
                choose_cal(t_cal_style'($urandom_range(2)));
            apply_cal(ph % 3 == 0);
            // Hold the receiver off while the sender keeps offering, so the pipe fills.
            if (ph == 1 || ph == 6) begin
                set_idling(IDLE_NONE);
                hold_requests++;
                repeat (BURST_ITEMS)
                    send_sample(pick_pressure(), pick_temperature());
            end
            set_idling(t_idle_mode'(ph % 4));
            repeat (ITEMS_PER_PHASE)
                send_sample(pick_pressure(), pick_temperature());
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (error_count == 0)
            $display("baro_pressure_temp_compensation_unit_tb: PASS");
        else
            $display("baro_pressure_temp_compensation_unit_tb: FAIL");
        $finish;
    end

endmodule

// File: filelist.f
sv/bpc_pkg.sv
sv/bpc_samp_if.sv
sv/bpc_res_if.sv
sv/bpc_apb_regs.sv
sv/bpc_pipe_ctrl.sv
sv/bpc_front.sv
sv/bpc_back.sv
sv/baro_pressure_temp_compensation_unit.sv
test/bpc_result_checker.sv
test/baro_pressure_temp_compensation_unit_tb.sv
